// ===== rtl/isr_pkg.sv =====
// isr_pkg: shared types, constants and sequencer states of the isaac random generator
// no dependencies; compile first
package isr_pkg;

    localparam int TABLE_WORDS = 256;
    localparam int IDX_W       = 8;
    localparam int WORD_W      = 32;
    localparam int RIDX_W      = 9;

    localparam logic [WORD_W-1:0] GOLDEN = 32'h9e37_79b9;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef word_t [7:0]       vec_t;

    typedef enum logic [1:0] {
        OP_SEED  = 2'd0,
        OP_INIT  = 2'd1,
        OP_FETCH = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_MIX,
        ST_P_RD,
        ST_P_ACC,
        ST_P_MIX,
        ST_P_WR,
        ST_G_START,
        ST_G_RX,
        ST_G_X,
        ST_G_ACC,
        ST_G_T,
        ST_G_Y,
        ST_G_RY,
        ST_G_L,
        ST_F_START,
        ST_F_RD,
        ST_F_OUT
    } state_t;

endpackage

// ===== rtl/isr_if.sv =====
// isr_if: valid/ready channel interfaces for command and response transfers
// depends on isr_pkg
interface isr_cmd_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [isr_pkg::IDX_W-1:0]  seed_index;
    logic [isr_pkg::WORD_W-1:0] seed_value;

    modport source (output valid, output opcode, output seed_index, output seed_value,
                    input ready);
    modport sink   (input valid, input opcode, input seed_index, input seed_value,
                    output ready);
endinterface

interface isr_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [isr_pkg::WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/isr_ram.sv =====
// isr_ram: 256 x 32 store, one write port and one registered read port
// depends on isr_pkg
module isr_ram (
    input  logic          clk,
    input  logic          we,
    input  isr_pkg::idx_t waddr,
    input  isr_pkg::word_t wdata,
    input  logic          re,
    input  isr_pkg::idx_t raddr,
    output isr_pkg::word_t rdata
);
    import isr_pkg::*;

    word_t mem [TABLE_WORDS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds its word while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/isr_mix.sv =====
// isr_mix: one round of the eight-word key mix, on a bank rotated to the round's word
// depends on isr_pkg
module isr_mix (
    input  isr_pkg::vec_t v,
    input  logic [2:0]    round,
    output isr_pkg::vec_t v_out
);
    import isr_pkg::*;

    word_t sh;
    word_t a;
    word_t b;
    word_t d;

    // shift of the neighbour word, left on even rounds
    always_comb
    begin
        unique case (round)
            3'd0: sh = v[1] << 11;
            3'd1: sh = v[1] >> 2;
            3'd2: sh = v[1] << 8;
            3'd3: sh = v[1] >> 16;
            3'd4: sh = v[1] << 10;
            3'd5: sh = v[1] >> 4;
            3'd6: sh = v[1] << 8;
            default: sh = v[1] >> 9;
        endcase
    end

    // xor, two adds, then rotate so the next round's word sits at the bottom
    always_comb
    begin
        a = v[0] ^ sh;
        d = v[3] + a;
        b = v[1] + v[2];
        v_out[0] = b;
        v_out[1] = v[2];
        v_out[2] = d;
        v_out[3] = v[4];
        v_out[4] = v[5];
        v_out[5] = v[6];
        v_out[6] = v[7];
        v_out[7] = a;
    end
endmodule

// ===== rtl/isaac_random_generator.sv =====
// isaac_random_generator: top level, sequencer over the result and internal stores
// depends on isr_pkg, isr_if, isr_ram, isr_mix
//
//  channel  dir  payload                          transfer
//  cmd      in   opcode, seed_index, seed_value   valid && ready
//  rsp      out  random_word                      valid && ready
//
// seed write: done in idle; fetch: reads one stored word, or first refills a set when the words run out
// (each new word steps through G_RX, G_X, G_ACC, G_T, G_Y, G_RY and G_L on the single internal store read port)
// init: 32 mix rounds, two passes of 32 groups, one set
// after reset a clearing pass over all 256 words zeroes both stores; cmd is not ready meanwhile
// cmd is taken only in idle; a fetch waits at its end while rsp still holds a word
module isaac_random_generator (
    input  logic clk,
    input  logic rst_n,
    isr_cmd_if.sink   cmd,
    isr_rsp_if.source rsp
);
    import isr_pkg::*;

    state_t state_reg, state_next;
    vec_t   v_reg, v_next;
    word_t  acc_reg, acc_next;
    word_t  last_reg, last_next;
    word_t  cnt_reg, cnt_next;
    word_t  x_reg, x_next;
    word_t  tmp_reg, tmp_next;
    logic [RIDX_W-1:0] ri_reg, ri_next;
    idx_t   idx_reg, idx_next;
    logic [4:0] rnd_reg, rnd_next;
    logic [4:0] grp_reg, grp_next;
    logic [2:0] k_reg, k_next;
    logic   pass_reg, pass_next;
    logic   gfetch_reg, gfetch_next;
    logic   rsp_valid_reg, rsp_valid_next;
    word_t  rsp_word_reg, rsp_word_next;

    logic   r_we, r_re, i_we, i_re;
    idx_t   r_waddr, r_raddr, i_waddr, i_raddr;
    word_t  r_wdata, i_wdata, r_rdata, i_rdata;
    vec_t   v_mixed;
    logic   cmd_xfer;

    isr_ram u_result (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
    );

    isr_ram u_internal (
        .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
        .re(i_re), .raddr(i_raddr), .rdata(i_rdata)
    );

    isr_mix u_mix (
        .v(v_reg), .round(rnd_reg[2:0]), .v_out(v_mixed)
    );

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_xfer    = cmd.valid && cmd.ready;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.random_word = rsp_word_reg;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            acc_reg       <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            ri_reg        <= '0;
            idx_reg       <= '0;
            rnd_reg       <= '0;
            grp_reg       <= '0;
            k_reg         <= '0;
            pass_reg      <= 1'b0;
            gfetch_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            ri_reg        <= ri_next;
            idx_reg       <= idx_next;
            rnd_reg       <= rnd_next;
            grp_reg       <= grp_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            gfetch_reg    <= gfetch_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        x_reg        <= x_next;
        tmp_reg      <= tmp_next;
        rsp_word_reg <= rsp_word_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        tmp_next       = tmp_reg;
        ri_next        = ri_reg;
        idx_next       = idx_reg;
        rnd_next       = rnd_reg;
        grp_next       = grp_reg;
        k_next         = k_reg;
        pass_next      = pass_reg;
        gfetch_next    = gfetch_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_word_next  = rsp_word_reg;
        r_we    = 1'b0;
        r_waddr = idx_reg;
        r_wdata = '0;
        r_re    = 1'b0;
        r_raddr = {grp_reg, k_reg};
        i_we    = 1'b0;
        i_waddr = idx_reg;
        i_wdata = '0;
        i_re    = 1'b0;
        i_raddr = {grp_reg, k_reg};

        unique case (state_reg)
            // zero both stores after reset
            ST_CLEAR:
            begin
                r_we = 1'b1;
                i_we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == idx_t'(TABLE_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            // take a command
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    priority case (opcode_t'(cmd.opcode))
                        OP_SEED:
                        begin
                            r_we    = 1'b1;
                            r_waddr = cmd.seed_index;
                            r_wdata = cmd.seed_value;
                        end
                        OP_INIT:  state_next = ST_INIT;
                        OP_FETCH: state_next = ST_F_START;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            // golden-ratio words, then four full mixes
            ST_INIT:
            begin
                for (int n = 0; n < 8; n++)
                begin
                    v_next[n] = GOLDEN;
                end
                rnd_next = '0;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                v_next = v_mixed;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == 5'd31)
                begin
                    pass_next = 1'b0;
                    grp_next = '0;
                    k_next = '0;
                    state_next = ST_P_RD;
                end
            end
            // mixing pass: fold in eight source words
            ST_P_RD:
            begin
                r_re = 1'b1;
                i_re = 1'b1;
                state_next = ST_P_ACC;
            end
            ST_P_ACC:
            begin
                for (int n = 0; n < 7; n++)
                begin
                    v_next[n] = v_reg[n + 1];
                end
                v_next[7] = v_reg[0] + (pass_reg ? i_rdata : r_rdata);
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd7)
                begin
                    rnd_next = '0;
                    state_next = ST_P_MIX;
                end
                else
                begin
                    state_next = ST_P_RD;
                end
            end
            ST_P_MIX:
            begin
                v_next = v_mixed;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg[2:0] == 3'd7)
                begin
                    state_next = ST_P_WR;
                end
            end
            // write the group back to the internal store
            ST_P_WR:
            begin
                i_we = 1'b1;
                i_waddr = {grp_reg, k_reg};
                i_wdata = v_reg[0];
                for (int n = 0; n < 7; n++)
                begin
                    v_next[n] = v_reg[n + 1];
                end
                v_next[7] = v_reg[0];
                k_next = k_reg + 1'b1;
                state_next = ST_P_WR;
                if (k_reg == 3'd7)
                begin
                    state_next = ST_P_RD;
                    grp_next = grp_reg + 1'b1;
                    if (grp_reg == 5'd31)
                    begin
                        pass_next = 1'b1;
                        if (pass_reg)
                        begin
                            gfetch_next = 1'b0;
                            state_next = ST_G_START;
                        end
                    end
                end
            end
            // new set: bump counter and last result
            ST_G_START:
            begin
                cnt_next = cnt_reg + 1'b1;
                last_next = last_reg + cnt_reg + 1'b1;
                idx_next = '0;
                state_next = ST_G_RX;
            end
            ST_G_RX:
            begin
                i_re = 1'b1;
                i_raddr = idx_reg;
                state_next = ST_G_X;
            end
            // x from the store, fetch the opposite half, shuffle the accumulator
            ST_G_X:
            begin
                x_next = i_rdata;
                i_re = 1'b1;
                i_raddr = {~idx_reg[IDX_W-1], idx_reg[IDX_W-2:0]};
                unique case (idx_reg[1:0])
                    2'd0: acc_next = acc_reg ^ (acc_reg << 13);
                    2'd1: acc_next = acc_reg ^ (acc_reg >> 6);
                    2'd2: acc_next = acc_reg ^ (acc_reg << 2);
                    default: acc_next = acc_reg ^ (acc_reg >> 16);
                endcase
                state_next = ST_G_ACC;
            end
            ST_G_ACC:
            begin
                acc_next = acc_reg + i_rdata;
                i_re = 1'b1;
                i_raddr = x_reg[IDX_W+1:2];
                state_next = ST_G_T;
            end
            ST_G_T:
            begin
                tmp_next = i_rdata + acc_reg;
                state_next = ST_G_Y;
            end
            ST_G_Y:
            begin
                tmp_next = tmp_reg + last_reg;
                i_we = 1'b1;
                i_waddr = idx_reg;
                i_wdata = tmp_reg + last_reg;
                state_next = ST_G_RY;
            end
            ST_G_RY:
            begin
                i_re = 1'b1;
                i_raddr = tmp_reg[IDX_W+9:10];
                state_next = ST_G_L;
            end
            // new result word
            ST_G_L:
            begin
                last_next = i_rdata + x_reg;
                r_we = 1'b1;
                r_waddr = idx_reg;
                r_wdata = i_rdata + x_reg;
                idx_next = idx_reg + 1'b1;
                state_next = ST_G_RX;
                if (idx_reg == idx_t'(TABLE_WORDS - 1))
                begin
                    if (gfetch_reg)
                    begin
                        ri_next = RIDX_W'(TABLE_WORDS - 1);
                        state_next = ST_F_RD;
                    end
                    else
                    begin
                        ri_next = RIDX_W'(TABLE_WORDS);
                        state_next = ST_IDLE;
                    end
                end
            end
            // fetch: step the read index, refill when the words run out
            ST_F_START:
            begin
                if (ri_reg == '0)
                begin
                    gfetch_next = 1'b1;
                    state_next = ST_G_START;
                end
                else
                begin
                    ri_next = ri_reg - 1'b1;
                    state_next = ST_F_RD;
                end
            end
            ST_F_RD:
            begin
                r_re = 1'b1;
                r_raddr = ri_reg[IDX_W-1:0];
                state_next = ST_F_OUT;
            end
            ST_F_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next = r_rdata;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // a response only appears at the end of a fetch
    a_rsp_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_F_OUT))
        else $error("response raised outside a fetch");

    // read index never passes the set size
    a_ri_range: assert property (@(posedge clk) disable iff (!rst_n)
        ri_reg <= RIDX_W'(TABLE_WORDS))
        else $error("read index out of range");

    // a pending response is never overwritten before its transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |=> rsp_valid_reg && $stable(rsp_word_reg))
        else $error("pending response lost");
endmodule
